FILE: rtl/bom_text_unit_decoder_assert.svh
// Assertion macros for the byte-order-mark text unit decoder.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BOM_TEXT_UNIT_DECODER_ASSERT_SVH
`define BOM_TEXT_UNIT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BOMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bomd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BOMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bomd next-cycle check failed");

`endif

FILE: rtl/bomd_pkg.sv
// Shared types and constants for the byte-order-mark text unit decoder.
// No dependencies; used by bomd_step and bom_text_unit_decoder.
package bomd_pkg;

    typedef enum logic [2:0] {
        MODE_UNDECIDED = 3'd0,
        MODE_BYTE      = 3'd1,
        MODE_BE16      = 3'd2,
        MODE_LE16      = 3'd3,
        MODE_BE32      = 3'd4,
        MODE_LE32      = 3'd5
    } t_mode;

    localparam logic [31:0] MARK32_BE = 32'h0000FEFF;
    localparam logic [31:0] MARK32_LE = 32'hFFFE0000;
    localparam logic [15:0] MARK16_BE = 16'hFEFF;
    localparam logic [15:0] MARK16_LE = 16'hFFFE;

    localparam logic [31:0] CH_NUL = 32'h00000000;
    localparam logic [31:0] CH_LF  = 32'h0000000A;
    localparam logic [31:0] CH_CR  = 32'h0000000D;

    localparam int MAX_RES = 4;

    typedef struct packed {
        t_mode             mode;
        logic [3:0][7:0]   hdr;
        logic [1:0]        hfill;
        logic [23:0]       partial;
        logic [1:0]        ufill;
        logic [31:0]       line;
        logic [31:0]       col;
    } t_state;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] line;
        logic [31:0] col;
        logic        status;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         cnt;
        logic               fin;
    } t_step;

    localparam t_state STATE_RESET = '{
        mode:    MODE_UNDECIDED,
        hdr:     '0,
        hfill:   2'd0,
        partial: 24'd0,
        ufill:   2'd0,
        line:    32'd0,
        col:     32'd0
    };

endpackage

FILE: rtl/bom_text_unit_decoder.sv
// Top level of the byte-order-mark text unit decoder: state, result buffer, ports.
// Depends on bomd_pkg, bomd_step and bom_text_unit_decoder_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) transfers one source byte with
//   i_final_byte set on the last byte of a source. Output channel
//   (o_out_valid / i_out_ready) transfers decoded code units with line and
//   column after each unit, a status bit for a truncated final unit, and
//   run_last / source_end markers. The config channel (i_cfg_valid /
//   o_cfg_ready, always ready) writes source_length; write it only while idle.
// Timing:
//   A byte is decoded in the cycle it is transferred; its results show up in
//   the result buffer in the next cycle. Each byte yields 0 to 4 results. While
//   the receiver is ready, results are driven one per cycle, and as the buffer
//   takes the next byte in the same cycle its last result transfers, one byte
//   per cycle is sustained while each byte yields at most one result; header
//   replay (up to 4 results) holds input off until it drains. The first bytes
//   of a source yield nothing until four are held or the final byte arrives.
// Reset (synchronous, active low) clears the decode state and source_length and
//   empties the result buffer, whose payload is not reset. A stalled receiver holds
//   the current result; input is held off until the buffer's last result is taken.
`include "bom_text_unit_decoder_assert.svh"

module bom_text_unit_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_source_length,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_char_value,
    output logic [31:0] o_line_count,
    output logic [31:0] o_column_count,
    output logic        o_status,
    output logic        o_run_last,
    output logic        o_source_end
);

    bomd_pkg::t_state r_st;
    bomd_pkg::t_state n_st;
    logic [31:0]      r_len;
    bomd_pkg::t_step  n_step;
    bomd_pkg::t_res [bomd_pkg::MAX_RES-1:0] r_res;
    logic [2:0]       r_left;
    logic [1:0]       r_rd;
    logic             r_fin;
    logic             in_xfer;
    logic             out_xfer;
    bomd_pkg::t_res   cur;

    bomd_step u_step (
        .i_st   (r_st),
        .i_len  (r_len),
        .i_byte (i_data_byte),
        .i_fin  (i_final_byte),
        .o_nst  (n_st),
        .o_step (n_step)
    );

    // Take a new byte once the buffer is empty or drains this cycle
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_left != 3'd0);
    assign out_xfer    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_left == 3'd0) || ((r_left == 3'd1) && i_out_ready);
    assign in_xfer     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 32'd0;
            r_st   <= bomd_pkg::STATE_RESET;
            r_left <= 3'd0;
            r_rd   <= 2'd0;
            r_fin  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_source_length;
            end
            if (in_xfer) begin
                r_st   <= n_st;
                r_left <= n_step.cnt;
                r_rd   <= 2'd0;
                r_fin  <= n_step.fin;
            end else if (out_xfer) begin
                r_left <= r_left - 3'd1;
                r_rd   <= r_rd + 2'd1;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_step.res;
        end
    end

    assign cur            = r_res[r_rd];
    assign o_char_value   = cur.value;
    assign o_line_count   = cur.line;
    assign o_column_count = cur.col;
    assign o_status       = cur.status;
    assign o_run_last     = (r_left == 3'd1);
    assign o_source_end   = (r_left == 3'd1) && r_fin;

    `BOMD_ASSERT_NOW(a_left_range, 1'b1, r_left <= 3'd4)
    `BOMD_ASSERT_NOW(a_no_overrun, in_xfer, (r_left == 3'd0) || ((r_left == 3'd1) && out_xfer))
    `BOMD_ASSERT_NEXT(a_fin_clears, in_xfer && i_final_byte,
        (r_st.mode == bomd_pkg::MODE_UNDECIDED) && (r_st.hfill == 2'd0) && (r_st.ufill == 2'd0))
    `BOMD_ASSERT_NOW(a_err_last, o_out_valid && o_status, o_run_last && o_source_end)

endmodule

FILE: rtl/bomd_step.sv
// Single-pass step logic: header capture, mark decision, unit assembly, line/column.
// Depends on bomd_pkg; instantiated by bom_text_unit_decoder.
module bomd_step (
    input  bomd_pkg::t_state i_st,
    input  logic [31:0]      i_len,
    input  logic [7:0]       i_byte,
    input  logic             i_fin,
    output bomd_pkg::t_state o_nst,
    output bomd_pkg::t_step  o_step
);

    logic [3:0][7:0] hb;
    logic [2:0]      nb;
    logic            trig;
    logic            elig4;
    logic            elig2;
    bomd_pkg::t_mode dmode;
    logic [31:0]     hword;
    logic [31:0]     v;
    logic [3:0][31:0] u;
    logic [2:0]      nu;
    logic [1:0]      ufill_n;
    logic [23:0]     partial_n;
    logic            err;
    logic [2:0]      ladd;
    logic [2:0]      since;
    logic            has_rst;
    logic            is_lf;
    logic            is_cr;

    // Header capture and mark decision
    always_comb begin
        hb           = i_st.hdr;
        hb[i_st.hfill] = i_byte;
        nb           = {1'b0, i_st.hfill} + 3'd1;
        trig         = (i_st.mode == bomd_pkg::MODE_UNDECIDED) && (nb[2] || i_fin);
        hword        = {hb[0], hb[1], hb[2], hb[3]};
        elig4        = (i_len != 32'd0) && (i_len[1:0] == 2'b00);
        elig2        = (i_len != 32'd0) && !i_len[0];
        dmode        = bomd_pkg::MODE_BYTE;
        if (nb[2] && elig4 && hword == bomd_pkg::MARK32_BE) begin
            dmode = bomd_pkg::MODE_BE32;
        end else if (nb[2] && elig4 && hword == bomd_pkg::MARK32_LE) begin
            dmode = bomd_pkg::MODE_LE32;
        end else if (nb >= 3'd2 && elig2 && hword[31:16] == bomd_pkg::MARK16_BE) begin
            dmode = bomd_pkg::MODE_BE16;
        end else if (nb >= 3'd2 && elig2 && hword[31:16] == bomd_pkg::MARK16_LE) begin
            dmode = bomd_pkg::MODE_LE16;
        end
    end

    // Unit assembly
    always_comb begin
        u         = '0;
        nu        = 3'd0;
        ufill_n   = i_st.ufill;
        partial_n = i_st.partial;
        v         = {i_st.partial, i_byte};
        if (i_st.mode == bomd_pkg::MODE_UNDECIDED) begin
            if (trig) begin
                ufill_n   = 2'd0;
                partial_n = 24'd0;
                case (dmode)
                    bomd_pkg::MODE_BE16: begin
                        u[0]    = {16'd0, hb[0], hb[1]};
                        u[1]    = {16'd0, hb[2], hb[3]};
                        nu      = {1'b0, nb[2:1]};
                        ufill_n = {1'b0, nb[0]};
                    end
                    bomd_pkg::MODE_LE16: begin
                        u[0]    = {16'd0, hb[1], hb[0]};
                        u[1]    = {16'd0, hb[3], hb[2]};
                        nu      = {1'b0, nb[2:1]};
                        ufill_n = {1'b0, nb[0]};
                    end
                    bomd_pkg::MODE_BE32: begin
                        u[0] = {hb[0], hb[1], hb[2], hb[3]};
                        nu   = 3'd1;
                    end
                    bomd_pkg::MODE_LE32: begin
                        u[0] = {hb[3], hb[2], hb[1], hb[0]};
                        nu   = 3'd1;
                    end
                    default: begin
                        for (int k = 0; k < bomd_pkg::MAX_RES; k++) begin
                            u[k] = {24'd0, hb[k]};
                        end
                        nu = nb;
                    end
                endcase
            end
        end else begin
            case (i_st.mode)
                bomd_pkg::MODE_BE16, bomd_pkg::MODE_LE16: begin
                    if (i_st.ufill == 2'd0) begin
                        partial_n = v[23:0];
                        ufill_n   = 2'd1;
                    end else begin
                        u[0] = (i_st.mode == bomd_pkg::MODE_LE16)
                             ? {16'd0, v[7:0], v[15:8]} : {16'd0, v[15:0]};
                        nu        = 3'd1;
                        partial_n = 24'd0;
                        ufill_n   = 2'd0;
                    end
                end
                bomd_pkg::MODE_BE32, bomd_pkg::MODE_LE32: begin
                    if (i_st.ufill != 2'd3) begin
                        partial_n = v[23:0];
                        ufill_n   = i_st.ufill + 2'd1;
                    end else begin
                        u[0] = (i_st.mode == bomd_pkg::MODE_LE32)
                             ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
                        nu        = 3'd1;
                        partial_n = 24'd0;
                        ufill_n   = 2'd0;
                    end
                end
                default: begin
                    u[0]      = v;
                    nu        = 3'd1;
                    partial_n = 24'd0;
                    ufill_n   = 2'd0;
                end
            endcase
        end
    end

    // Line/column per result slot; a slot past the units carries the truncation error
    always_comb begin
        err     = i_fin && (ufill_n != 2'd0);
        ladd    = 3'd0;
        since   = 3'd0;
        has_rst = 1'b0;
        is_lf   = 1'b0;
        is_cr   = 1'b0;
        o_step  = '0;
        for (int k = 0; k < bomd_pkg::MAX_RES; k++) begin
            if (3'(k) < nu) begin
                is_lf = (u[k] == bomd_pkg::CH_LF) || (u[k] == bomd_pkg::CH_NUL);
                is_cr = (u[k] == bomd_pkg::CH_CR);
                ladd  = ladd + {2'b00, is_lf};
                if (is_lf || is_cr) begin
                    has_rst = 1'b1;
                    since   = 3'd0;
                end else begin
                    since = since + 3'd1;
                end
            end
            o_step.res[k].value  = (3'(k) < nu) ? u[k] : 32'd0;
            o_step.res[k].status = !(3'(k) < nu);
            o_step.res[k].line   = i_st.line + {29'd0, ladd};
            o_step.res[k].col    = has_rst ? {29'd0, since} : i_st.col + {29'd0, since};
        end
        o_step.cnt = nu + {2'b00, err};
        o_step.fin = i_fin;
    end

    // Next state
    always_comb begin
        if (i_fin) begin
            o_nst = bomd_pkg::STATE_RESET;
        end else begin
            o_nst         = i_st;
            o_nst.mode    = trig ? dmode : i_st.mode;
            o_nst.hdr     = (i_st.mode == bomd_pkg::MODE_UNDECIDED) ? hb : i_st.hdr;
            o_nst.hfill   = (i_st.mode == bomd_pkg::MODE_UNDECIDED) ? nb[1:0] : i_st.hfill;
            o_nst.partial = partial_n;
            o_nst.ufill   = ufill_n;
            o_nst.line    = o_step.res[bomd_pkg::MAX_RES-1].line;
            o_nst.col     = o_step.res[bomd_pkg::MAX_RES-1].col;
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for bom_text_unit_decoder: random and directed byte sources,
// an in-bench decoder that predicts every code unit, and a field-by-field checker.
// Depends on bomd_pkg for the mode codes, byte-order marks and control characters.
module tb_top;

    localparam int SETTLE_CYCLES = 4;        // slack after the last unit for header bytes
    localparam int LONG_HOLD     = 150;      // receiver hold-off that backs up the input
    localparam int PHASE_BYTES   = 75;       // random bytes per idling phase

    // One byte of a source as the sender presents it.
    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_src_byte;

    // One decoded code unit as the output channel should carry it.
    typedef struct {
        logic [31:0] value;
        logic [31:0] line;
        logic [31:0] col;
        logic        status;
        logic        run_last;
        logic        source_end;
    } t_unit_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_source_length = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_final_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_char_value;
    logic [31:0] o_line_count;
    logic [31:0] o_column_count;
    logic        o_status;
    logic        o_run_last;
    logic        o_source_end;

    // Bytes waiting for the driver, and units waiting for the checker.
    t_src_byte   bytes_to_send[$];
    t_unit_rec   units_due[$];
    t_unit_rec   step_units[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned mismatches = 0;

    // Idle rates in percent, set per phase by the stimulus process.
    int unsigned send_gap_pct = 12;
    int unsigned recv_gap_pct = 83;

    // Long receiver hold-offs: the stimulus bumps the request count, the
    // receiver process serves each request once and counts the cycles itself.
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    // Predicted decoder state and the source_length register copy.
    bomd_pkg::t_mode dec_mode;
    logic [7:0]  dec_hdr [4];
    int unsigned dec_hfill;
    logic [23:0] dec_partial;
    int unsigned dec_ufill;
    logic [31:0] dec_line;
    logic [31:0] dec_col;
    logic [31:0] dec_len;

    bom_text_unit_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_source_length(i_source_length),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_char_value   (o_char_value),
        .o_line_count   (o_line_count),
        .o_column_count (o_column_count),
        .o_status       (o_status),
        .o_run_last     (o_run_last),
        .o_source_end   (o_source_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Return to the start-of-source state; source_length is kept.
    function automatic void clear_decoder();
        dec_mode = bomd_pkg::MODE_UNDECIDED;
        foreach (dec_hdr[k]) dec_hdr[k] = '0;
        dec_hfill = 0;
        dec_partial = '0;
        dec_ufill = 0;
        dec_line = '0;
        dec_col = '0;
    endfunction

    function automatic void push_unit(logic [31:0] value, logic status);
        t_unit_rec u;
        u.value = value;
        u.line = dec_line;
        u.col = dec_col;
        u.status = status;
        u.run_last = 1'b0;
        u.source_end = 1'b0;
        step_units.push_back(u);
    endfunction

    // Pick the code unit from the held header bytes. Try the four-byte marks
    // first, so FF FE 00 00 reads as UTF-32 little endian when eligible.
    function automatic void choose_mode();
        logic [31:0] head4;
        logic [15:0] head2;
        head4 = {dec_hdr[0], dec_hdr[1], dec_hdr[2], dec_hdr[3]};
        head2 = {dec_hdr[0], dec_hdr[1]};
        dec_mode = bomd_pkg::MODE_BYTE;
        if (dec_hfill >= 4 && dec_len >= 4 && dec_len[1:0] == 2'b00) begin
            if (head4 == bomd_pkg::MARK32_BE) begin
                dec_mode = bomd_pkg::MODE_BE32;
                return;
            end
            if (head4 == bomd_pkg::MARK32_LE) begin
                dec_mode = bomd_pkg::MODE_LE32;
                return;
            end
        end
        if (dec_hfill >= 2 && dec_len >= 2 && dec_len[0] == 1'b0) begin
            if (head2 == bomd_pkg::MARK16_BE) dec_mode = bomd_pkg::MODE_BE16;
            else if (head2 == bomd_pkg::MARK16_LE) dec_mode = bomd_pkg::MODE_LE16;
        end
    endfunction

    // Shift one byte into the unit being built; emit the unit when complete.
    function automatic void assemble(logic [7:0] b);
        int unsigned width;
        logic [31:0] v;
        if (dec_mode == bomd_pkg::MODE_BE16 || dec_mode == bomd_pkg::MODE_LE16) width = 2;
        else if (dec_mode == bomd_pkg::MODE_BE32 || dec_mode == bomd_pkg::MODE_LE32) width = 4;
        else width = 1;
        v = {dec_partial, b};
        if (dec_ufill + 1 < width) begin
            dec_partial = v[23:0];
            dec_ufill++;
            return;
        end
        if (dec_mode == bomd_pkg::MODE_LE16) v = {16'h0000, v[7:0], v[15:8]};
        else if (dec_mode == bomd_pkg::MODE_LE32) v = {v[7:0], v[15:8], v[23:16], v[31:24]};
        dec_partial = '0;
        dec_ufill = 0;
        dec_col++;
        // LF and NUL end a line; CR only returns the column.
        if (v == bomd_pkg::CH_LF || v == bomd_pkg::CH_CR || v == bomd_pkg::CH_NUL) begin
            dec_col = '0;
            if (v != bomd_pkg::CH_CR) dec_line++;
        end
        push_unit(v, 1'b0);
    endfunction

    // Predict the units that one transferred byte causes and queue them.
    function automatic void decode_byte(logic [7:0] b, logic fin);
        int unsigned i;
        step_units.delete();
        if (dec_mode == bomd_pkg::MODE_UNDECIDED) begin
            dec_hdr[dec_hfill % 4] = b;
            dec_hfill++;
            if (dec_hfill >= 4 || fin) begin
                choose_mode();
                for (i = 0; i < dec_hfill && i < 4; i++) assemble(dec_hdr[i]);
            end
        end else begin
            assemble(b);
        end
        if (fin) begin
            // A final byte that leaves a partial unit gives one error unit.
            if (dec_ufill != 0) push_unit('0, 1'b1);
            if (step_units.size() > 0) step_units[$].source_end = 1'b1;
            clear_decoder();
        end
        if (step_units.size() > 0) step_units[$].run_last = 1'b1;
        foreach (step_units[k]) units_due.push_back(step_units[k]);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued bytes, hold each until its transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        logic      busy;
        t_src_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_data_byte, i_final_byte);
                bytes_taken++;
                busy = 1'b0;
            end
            // Once free, either offer the next byte or leave the input idle.
            if (!busy) begin
                if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = bytes_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_final_byte <= nxt.fin;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each transferred unit with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_units
        t_unit_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (units_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected unit value %h line %0d col %0d status %b",
                             $realtime, o_char_value, o_line_count, o_column_count,
                             o_status);
            end else begin
                want = units_due.pop_front();
                if (o_char_value !== want.value || o_line_count !== want.line ||
                    o_column_count !== want.col || o_status !== want.status ||
                    o_run_last !== want.run_last || o_source_end !== want.source_end) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unit mismatch, expected %h line %0d col %0d",
                                 $realtime, want.value, want.line, want.col);
                        $display("          expected st %b last %b end %b",
                                 want.status, want.run_last, want.source_end);
                        $display("          got      %h line %0d col %0d",
                                 o_char_value, o_line_count, o_column_count);
                        $display("          got      st %b last %b end %b",
                                 o_status, o_run_last, o_source_end);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one whole source; the last byte carries the final flag.
    task automatic queue_text(input logic [7:0] seq[$]);
        t_src_byte sb;
        foreach (seq[k]) begin
            sb.data = seq[k];
            sb.fin = (k == seq.size() - 1);
            bytes_to_send.push_back(sb);
            bytes_queued++;
        end
    endtask

    // Favor bytes that steer the decoder: line ends, NUL and mark bytes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return bomd_pkg::CH_NUL[7:0];
            1: return bomd_pkg::CH_LF[7:0];
            2: return bomd_pkg::CH_CR[7:0];
            3: return 8'hFE;
            4: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Build a source of n bytes, led by the mark of the given mode (if any).
    // A short n cuts the mark, which gives broken headers for free.
    task automatic queue_source(input bomd_pkg::t_mode mark, input int unsigned n);
        logic [31:0] mark_word;
        int unsigned mark_len;
        logic [7:0]  seq[$];
        int unsigned k;
        mark_word = '0;
        mark_len = 0;
        case (mark)
            bomd_pkg::MODE_BE32: begin
                mark_word = bomd_pkg::MARK32_BE;
                mark_len = 4;
            end
            bomd_pkg::MODE_LE32: begin
                mark_word = bomd_pkg::MARK32_LE;
                mark_len = 4;
            end
            bomd_pkg::MODE_BE16: begin
                mark_word = {bomd_pkg::MARK16_BE, 16'h0000};
                mark_len = 2;
            end
            bomd_pkg::MODE_LE16: begin
                mark_word = {bomd_pkg::MARK16_LE, 16'h0000};
                mark_len = 2;
            end
            default: mark_len = 0;
        endcase
        for (k = 0; k < n; k++) begin
            if (k < mark_len) seq.push_back(mark_word[31 - 8*k -: 8]);
            else seq.push_back(pick_byte());
        end
        queue_text(seq);
    endtask

    // Wait until every queued byte has transferred and every unit arrived,
    // then give the block time to finish bytes that cause no unit.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (bytes_taken != bytes_queued || units_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write source_length; call only while the block is idle.
    task automatic set_source_length(input logic [31:0] len);
        i_cfg_valid <= 1'b1;
        i_source_length <= len;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        dec_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    // One configuration group: drain, pick a length (extremes included),
    // then send a few sources, most of them well formed for that length.
    task automatic run_group(input logic long_hold);
        logic [31:0]     cfg;
        int unsigned     n;
        int unsigned     count;
        bomd_pkg::t_mode mark;
        case ($urandom_range(9))
            0: cfg = 32'h0000_0000;
            1: cfg = 32'hFFFF_FFFF;
            2: cfg = 32'hFFFF_FFFC;
            3: cfg = $urandom();
            default: cfg = $urandom_range(1, 12);
        endcase
        wait_drained();
        set_source_length(cfg);
        if (long_hold) hold_requests++;
        count = $urandom_range(2, 5);
        repeat (count) begin
            if (cfg != 0 && cfg <= 12 && $urandom_range(3) != 0) n = cfg;
            else n = $urandom_range(1, 12);
            case ($urandom_range(9))
                1, 2: mark = bomd_pkg::MODE_BE32;
                3, 4: mark = bomd_pkg::MODE_LE32;
                5, 6: mark = bomd_pkg::MODE_BE16;
                7, 8: mark = bomd_pkg::MODE_LE16;
                default: mark = bomd_pkg::MODE_BYTE;
            endcase
            queue_source(mark, n);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        logic [7:0]  seq[$];
        int unsigned phase;
        clear_decoder();
        dec_len = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: UTF-32 big endian with LF, then FF FE 00 00 which must
        // win as UTF-32 little endian over the two-byte mark.
        set_source_length(32'd8);
        seq = '{8'h00, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h0A};
        queue_text(seq);
        seq = '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h00, 8'h00};
        queue_text(seq);
        wait_drained();

        // Short header: three bytes cannot hold a four-byte mark, so FF FE 00
        // is UTF-16 little endian with a truncated last unit. Then a bare
        // UTF-16 big-endian mark decided on the final byte.
        set_source_length(32'd4);
        seq = '{8'hFF, 8'hFE, 8'h00};
        queue_text(seq);
        seq = '{8'hFE, 8'hFF};
        queue_text(seq);
        wait_drained();

        // Zero length: no mark is eligible, so FE FF are plain bytes.
        set_source_length(32'h0000_0000);
        seq = '{8'hFE, 8'hFF};
        queue_text(seq);
        wait_drained();

        // All-ones length is odd: single-byte sources of both byte extremes.
        set_source_length(32'hFFFF_FFFF);
        seq = '{8'hFF};
        queue_text(seq);
        seq = '{8'h00};
        queue_text(seq);

        // Random phases: sender rarely idles, then receiver rarely idles,
        // then neither idles and the receiver takes one long hold-off.
        for (phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin send_gap_pct = 12; recv_gap_pct = 83; end
                1: begin send_gap_pct = 83; recv_gap_pct = 12; end
                default: begin send_gap_pct = 0; recv_gap_pct = 0; end
            endcase
            run_group(phase == 2);
            while (bytes_queued < 25 + PHASE_BYTES * (phase + 1)) run_group(1'b0);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && units_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bomd_pkg.sv
rtl/bomd_step.sv
rtl/bom_text_unit_decoder.sv
tb/sv/tb_top.sv
